>>> sv/quadratic_root_solver_macros.svh
// Assertion helpers for the quadratic root solver.
// Each macro expects the signals clk and arst_n in the scope where it is used.
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define QRS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define QRS_ASSERT_IMP(lbl, ante, cons, msg)
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/qrs_pkg.sv
`default_nettype none

package qrs_pkg;

	// Result codes.
	typedef enum logic [1:0] {
		OUT_ROOTS = 2'd0,
		OUT_NONE  = 2'd1,
		OUT_ANY   = 2'd2
	} outcome_t;

	localparam int COEF_W   = 24;
	localparam int TOL_W    = 23;
	localparam int ROOT_W   = 32;
	localparam int SQ_STEPS = 29;   // result bits of the square root
	localparam int SQ_IN_W  = 2 * SQ_STEPS;
	localparam int SQ_REM_W = SQ_STEPS + 2;
	localparam int DIV_STEPS = 33;  // quotient bits produced by the divider
	localparam int NUM_W    = 44;
	localparam int DEN_W    = 30;

	// Coefficients carried alongside the square root.
	typedef struct packed {
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] c;
		outcome_t                 outcome;
		logic                     lin;
	} item_t;

	// One stage of the square root pipeline.
	typedef struct packed {
		logic [SQ_IN_W-1:0]  v;
		logic [SQ_REM_W-1:0] rem;
		logic [SQ_STEPS-1:0] root;
		item_t               item;
	} sq_t;

	// One stage of the two-lane divider pipeline.
	typedef struct packed {
		logic [NUM_W-1:0]     rem1;
		logic [NUM_W-1:0]     rem2;
		logic [DEN_W-1:0]     d;
		logic [DIV_STEPS-1:0] q1;
		logic [DIV_STEPS-1:0] q2;
		logic                 neg1;
		logic                 neg2;
		logic                 ovf1;
		logic                 ovf2;
		outcome_t             outcome;
	} div_t;

	// Magnitude of a signed coefficient.
	function automatic logic [COEF_W-1:0] mag24(input logic [COEF_W-1:0] v);
		mag24 = v[COEF_W-1] ? (~v + 1'b1) : v;
	endfunction

	// Apply the sign and saturate to Q20.12; returns {clip, root}.
	function automatic logic [ROOT_W:0] sat_root(input logic [DIV_STEPS-1:0] q,
			input logic neg, input logic ovf);
		logic big;
		logic [ROOT_W-1:0] r;
		big = ovf || q[DIV_STEPS-1];
		r = '0;
		if (!neg) begin
			if (big || q[ROOT_W-1]) begin
				sat_root = {1'b1, 1'b0, {(ROOT_W-1){1'b1}}};
			end else begin
				sat_root = {1'b0, q[ROOT_W-1:0]};
			end
		end else begin
			if (big || (q[ROOT_W-1] && (q[ROOT_W-2:0] != '0))) begin
				sat_root = {1'b1, 1'b1, {(ROOT_W-1){1'b0}}};
			end else begin
				r = ~q[ROOT_W-1:0] + 1'b1;
				sat_root = {1'b0, r};
			end
		end
	endfunction

endpackage

`default_nettype wire

>>> sv/qrs_sqrt.sv
`default_nettype none

// Pipelined integer square root, one result bit per stage.
module qrs_sqrt (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         in_valid,
	input  wire qrs_pkg::sq_t in_data,
	output logic              out_valid,
	output qrs_pkg::sq_t      out_data
);
	import qrs_pkg::*;

	logic vld_s [SQ_STEPS];
	sq_t  sq_s  [SQ_STEPS];

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
		sq_t prev;
		sq_t nxt;
		logic pv;
		logic [SQ_REM_W-1:0] acc;
		logic [SQ_REM_W-1:0] trial;

		if (i == 0) begin : g_first
			assign prev = in_data;
			assign pv = in_valid;
		end else begin : g_rest
			assign prev = sq_s[i-1];
			assign pv = vld_s[i-1];
		end

		// Bring down the next bit pair and try to subtract 4r+1.
		always_comb begin
			acc = {prev.rem[SQ_REM_W-3:0], prev.v[2*(SQ_STEPS-1-i) +: 2]};
			trial = {prev.root, 2'b01};
			nxt = prev;
			if (acc >= trial) begin
				nxt.rem = acc - trial;
				nxt.root = {prev.root[SQ_STEPS-2:0], 1'b1};
			end else begin
				nxt.rem = acc;
				nxt.root = {prev.root[SQ_STEPS-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[i] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[SQ_STEPS-1];
	assign out_data = sq_s[SQ_STEPS-1];

	`include "quadratic_root_solver_macros.svh"

	`QRS_ASSERT_IMP(a_sq_rem_bound, out_valid,
		{1'b0, out_data.rem} <= {out_data.root, 1'b0}, "sqrt remainder exceeds 2r")
	`QRS_ASSERT_IMP(a_sq_exact, out_valid,
		({29'b0, out_data.root} * {29'b0, out_data.root}) + {27'b0, out_data.rem}
			== out_data.v, "sqrt does not reconstruct its operand")
	`QRS_ASSERT_NEXT(a_sq_hold, !en, $stable(out_valid), "sqrt output moved while stalled")

endmodule

`default_nettype wire

>>> sv/qrs_div.sv
`default_nettype none

// Pipelined restoring divider, two numerators over a shared divisor,
// one quotient bit per stage from the top bit down.
module qrs_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire qrs_pkg::div_t in_data,
	output logic               out_valid,
	output qrs_pkg::div_t      out_data
);
	import qrs_pkg::*;

	logic vld_s [DIV_STEPS];
	div_t dv_s  [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		div_t prev;
		div_t nxt;
		logic pv;
		logic [63:0] dsh;
		logic ge1;
		logic ge2;

		if (j == 0) begin : g_first
			assign prev = in_data;
			assign pv = in_valid;
		end else begin : g_rest
			assign prev = dv_s[j-1];
			assign pv = vld_s[j-1];
		end

		// Compare each remainder with the divisor shifted to this bit.
		always_comb begin
			dsh = {{(64-DEN_W){1'b0}}, prev.d} << (DIV_STEPS - 1 - j);
			ge1 = {{(64-NUM_W){1'b0}}, prev.rem1} >= dsh;
			ge2 = {{(64-NUM_W){1'b0}}, prev.rem2} >= dsh;
			nxt = prev;
			nxt.rem1 = ge1 ? (prev.rem1 - dsh[NUM_W-1:0]) : prev.rem1;
			nxt.rem2 = ge2 ? (prev.rem2 - dsh[NUM_W-1:0]) : prev.rem2;
			nxt.q1 = {prev.q1[DIV_STEPS-2:0], ge1};
			nxt.q2 = {prev.q2[DIV_STEPS-2:0], ge2};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[j] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[DIV_STEPS-1];
	assign out_data = dv_s[DIV_STEPS-1];

	`include "quadratic_root_solver_macros.svh"

	`QRS_ASSERT_IMP(a_div_rem1, out_valid && !out_data.ovf1,
		out_data.rem1 < {{(NUM_W-DEN_W){1'b0}}, out_data.d}, "lane one remainder too big")
	`QRS_ASSERT_IMP(a_div_rem2, out_valid && !out_data.ovf2,
		out_data.rem2 < {{(NUM_W-DEN_W){1'b0}}, out_data.d}, "lane two remainder too big")
	`QRS_ASSERT_NEXT(a_div_hold, !en, $stable(out_valid), "divider moved while stalled")

endmodule

`default_nettype wire

>>> sv/quadratic_root_solver.sv
`default_nettype none

// Quadratic root solver: takes one coefficient triple (a, b, c, signed Q12.12)
// per transaction and returns one result transaction holding an outcome code,
// two Q20.12 roots saturated to 32 bits, and a flag set when either root was
// clipped. With |a| below the tolerance the equation is solved as linear and
// both roots equal -c/b (if |b| is also below it, no or any solution is
// reported); otherwise the roots are (-b +/- sqrt(b*b - 4ac))/2a, and a
// discriminant below the tolerance reports no real solution. The block
// accepts a new triple every clock cycle while s_tready is high. A triple
// passes through 68 registers: three input stages, the 29-stage square root,
// two stages that prepare the division, the 33-stage divider and the output
// register. When the output is not taken the whole pipeline holds and
// s_tready drops. The tolerance register may be written only while idle.
module quadratic_root_solver (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        tolerance_we,
	input  wire logic [22:0] tolerance_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // coef_a, coef_b, coef_c
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0] m_tdata    // outcome, root_one, root_two, clipped, zero pad
);
	import qrs_pkg::*;

	logic en;
	logic [TOL_W-1:0] tol_q;

	// Pipeline advances whenever the output register is free or being emptied.
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// Tolerance register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_W'(1);
		end else if (tolerance_we) begin
			tol_q <= tolerance_wdata;
		end
	end

	// Stage 1: register the coefficients and the effective tolerance.
	logic vld_s1;
	logic signed [COEF_W-1:0] a_s1, b_s1, c_s1;
	logic [TOL_W-1:0] eps_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= s_tdata[23:0];
			b_s1 <= s_tdata[47:24];
			c_s1 <= s_tdata[71:48];
			eps_s1 <= (tol_q == '0) ? TOL_W'(1) : tol_q;
		end
	end

	// Stage 2: products for the discriminant and the near-zero tests.
	logic vld_s2;
	logic signed [COEF_W-1:0] a_s2, b_s2, c_s2;
	logic [TOL_W-1:0] eps_s2;
	logic signed [2*COEF_W-1:0] bb_s2, ac_s2;
	logic sa_s2, sb_s2, sc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			c_s2 <= c_s1;
			eps_s2 <= eps_s1;
			bb_s2 <= b_s1 * b_s1;
			ac_s2 <= a_s1 * c_s1;
			sa_s2 <= mag24(a_s1) < {1'b0, eps_s1};
			sb_s2 <= mag24(b_s1) < {1'b0, eps_s1};
			sc_s2 <= mag24(c_s1) < {1'b0, eps_s1};
		end
	end

	// Stage 3: discriminant, case decision and square root operand.
	logic signed [49:0] disc;
	logic disc_low;
	sq_t sq_in;
	logic vld_s3;
	sq_t sq_in_s3;

	always_comb begin
		disc = {{2{bb_s2[47]}}, bb_s2} - {ac_s2, 2'b00};
		disc_low = disc < $signed({15'b0, eps_s2, 12'b0});
		sq_in.rem = '0;
		sq_in.root = '0;
		sq_in.v = '0;
		sq_in.item.a = a_s2;
		sq_in.item.b = b_s2;
		sq_in.item.c = c_s2;
		sq_in.item.lin = 1'b0;
		sq_in.item.outcome = OUT_ROOTS;
		if (sa_s2) begin
			sq_in.item.lin = 1'b1;
			if (sb_s2 && sc_s2) begin
				sq_in.item.outcome = OUT_ANY;
			end else if (sb_s2) begin
				sq_in.item.outcome = OUT_NONE;
			end
		end else if (disc_low) begin
			sq_in.item.outcome = OUT_NONE;
		end else begin
			sq_in.v = {disc, 8'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_in_s3 <= sq_in;
		end
	end

	// Square root of the scaled discriminant.
	logic sq_vld;
	sq_t sq_out;

	qrs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.in_data  (sq_in_s3),
		.out_valid(sq_vld),
		.out_data (sq_out)
	);

	// Stage 4: signed numerators and the divisor magnitude.
	logic signed [30:0] nb, t1, t2, nc, n1, n2;
	logic [30:0] m1, m2;
	logic [COEF_W-1:0] amag, bmag;
	logic vld_s4;
	logic [29:0] nm1_s4, nm2_s4;
	logic [28:0] dm_s4;
	logic neg1_s4, neg2_s4;
	outcome_t oc_s4;

	always_comb begin
		nb = -{{3{sq_out.item.b[23]}}, sq_out.item.b, 4'b0};
		t1 = nb + {2'b0, sq_out.root};
		t2 = nb - {2'b0, sq_out.root};
		nc = -{{7{sq_out.item.c[23]}}, sq_out.item.c};
		n1 = sq_out.item.lin ? nc : t1;
		n2 = sq_out.item.lin ? nc : t2;
		m1 = n1[30] ? (~n1 + 1'b1) : n1;
		m2 = n2[30] ? (~n2 + 1'b1) : n2;
		amag = mag24(sq_out.item.a);
		bmag = mag24(sq_out.item.b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nm1_s4 <= m1[29:0];
			nm2_s4 <= m2[29:0];
			dm_s4 <= sq_out.item.lin ? {5'b0, bmag} : {amag, 5'b0};
			neg1_s4 <= n1[30] != (sq_out.item.lin ? sq_out.item.b[23] : sq_out.item.a[23]);
			neg2_s4 <= n2[30] != (sq_out.item.lin ? sq_out.item.b[23] : sq_out.item.a[23]);
			oc_s4 <= sq_out.item.outcome;
		end
	end

	// Stage 5: rounding-biased dividends and the overflow precheck.
	div_t dv_in;
	logic [63:0] dtop;
	logic vld_s5;
	div_t dv_in_s5;

	always_comb begin
		dv_in.rem1 = {1'b0, nm1_s4, 13'b0} + {15'b0, dm_s4};
		dv_in.rem2 = {1'b0, nm2_s4, 13'b0} + {15'b0, dm_s4};
		dv_in.d = {dm_s4, 1'b0};
		dv_in.q1 = '0;
		dv_in.q2 = '0;
		dv_in.neg1 = neg1_s4;
		dv_in.neg2 = neg2_s4;
		dv_in.outcome = oc_s4;
		dtop = {{(64-DEN_W){1'b0}}, dv_in.d} << DIV_STEPS;
		dv_in.ovf1 = {20'b0, dv_in.rem1} >= dtop;
		dv_in.ovf2 = {20'b0, dv_in.rem2} >= dtop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_in_s5 <= dv_in;
		end
	end

	// Rounded quotients.
	logic dv_vld;
	div_t dv_out;

	qrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s5),
		.in_data  (dv_in_s5),
		.out_valid(dv_vld),
		.out_data (dv_out)
	);

	// Stage 6: sign, saturation and the output register.
	logic [ROOT_W:0] r1, r2;
	outcome_t oc_s6;
	logic [ROOT_W-1:0] root1_s6, root2_s6;
	logic clip_s6;

	always_comb begin
		r1 = sat_root(dv_out.q1, dv_out.neg1, dv_out.ovf1);
		r2 = sat_root(dv_out.q2, dv_out.neg2, dv_out.ovf2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oc_s6 <= dv_out.outcome;
			if (dv_out.outcome == OUT_ROOTS) begin
				root1_s6 <= r1[ROOT_W-1:0];
				root2_s6 <= r2[ROOT_W-1:0];
				clip_s6 <= r1[ROOT_W] || r2[ROOT_W];
			end else begin
				root1_s6 <= '0;
				root2_s6 <= '0;
				clip_s6 <= 1'b0;
			end
		end
	end

	assign m_tdata = {5'b0, clip_s6, root2_s6, root1_s6, oc_s6};

	`include "quadratic_root_solver_macros.svh"

	`QRS_ASSERT_IMP(a_no_roots_zero, m_tvalid && (oc_s6 != OUT_ROOTS),
		(root1_s6 == '0) && (root2_s6 == '0) && !clip_s6, "roots present without a solution")
	`QRS_ASSERT_IMP(a_clip_roots, clip_s6, oc_s6 == OUT_ROOTS, "clip flag without roots")
	`QRS_ASSERT_IMP(a_clip_sat, m_tvalid && clip_s6,
		(root1_s6 == 32'h7FFF_FFFF) || (root1_s6 == 32'h8000_0000) ||
		(root2_s6 == 32'h7FFF_FFFF) || (root2_s6 == 32'h8000_0000),
		"clip flag without a saturated root")

endmodule

`default_nettype wire
